FILE: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/tvsg_pkg.sv
// ----------------------------------------------------------------------------
// tvsg_pkg
// types and constants shared by the three voice sound generator
// ----------------------------------------------------------------------------
package tvsg_pkg;

   typedef enum logic [1:0] {
      BUS_IDLE  = 2'd0,
      BUS_READ  = 2'd1,
      BUS_WRITE = 2'd2,
      BUS_LATCH = 2'd3
   } bus_ctl_type;

   localparam logic KIND_BUS  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // register file addresses
   localparam logic [3:0] REG_TONE_A_LO = 4'd0;
   localparam logic [3:0] REG_TONE_A_HI = 4'd1;
   localparam logic [3:0] REG_TONE_B_LO = 4'd2;
   localparam logic [3:0] REG_TONE_B_HI = 4'd3;
   localparam logic [3:0] REG_TONE_C_LO = 4'd4;
   localparam logic [3:0] REG_TONE_C_HI = 4'd5;
   localparam logic [3:0] REG_NOISE     = 4'd6;
   localparam logic [3:0] REG_MIXER     = 4'd7;
   localparam logic [3:0] REG_VOL_A     = 4'd8;
   localparam logic [3:0] REG_VOL_B     = 4'd9;
   localparam logic [3:0] REG_VOL_C     = 4'd10;
   localparam logic [3:0] REG_ENV_LO    = 4'd11;
   localparam logic [3:0] REG_ENV_HI    = 4'd12;
   localparam logic [3:0] REG_SHAPE     = 4'd13;
   localparam logic [3:0] REG_PORT_A    = 4'd14;
   localparam logic [3:0] REG_PORT_B    = 4'd15;

   localparam logic [17:0] LFSR_TAPS = 18'h24000;
   localparam logic [3:0]  KEY_ROWS  = 4'd10;
   localparam logic [7:0]  BUS_FLOAT = 8'hFF;
   localparam int unsigned VOICES    = 3;

   // mixer bits
   localparam int unsigned MIX_NOISE_OFS = 3;
   localparam int unsigned MIX_PORT_A_IN = 6;
   localparam int unsigned MIX_PORT_B_IN = 7;

   // envelope shape bits
   localparam int unsigned SHAPE_HOLD   = 0;
   localparam int unsigned SHAPE_ALT    = 1;
   localparam int unsigned SHAPE_ATTACK = 2;
   localparam int unsigned SHAPE_CONT   = 3;

   typedef struct packed {
      logic        kind;
      bus_ctl_type ctl;
      logic [7:0]  data;
      logic [3:0]  row;
      logic [7:0]  key;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] level_left;
      logic [3:0] level_center;
      logic [3:0] level_right;
   } rsp_item_type;

endpackage

FILE: design/tvsg_engine.sv
// ----------------------------------------------------------------------------
// tvsg_engine
// register file, tone, noise and envelope state; one item per fire
// ----------------------------------------------------------------------------
module tvsg_engine import tvsg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [7:0]  sel_ff, sel_in;
   logic [7:0]  tone_lo_ff [VOICES];
   logic [7:0]  tone_lo_in [VOICES];
   logic [3:0]  tone_hi_ff [VOICES];
   logic [3:0]  tone_hi_in [VOICES];
   logic [4:0]  vol_ff [VOICES];
   logic [4:0]  vol_in [VOICES];
   logic [11:0] tone_cnt_ff [VOICES];
   logic [11:0] tone_cnt_in [VOICES];
   logic        tone_lvl_ff [VOICES];
   logic        tone_lvl_in [VOICES];
   logic [4:0]  noise_ff, noise_in;
   logic [7:0]  reg7_ff, reg7_in;
   logic [7:0]  mixer_ff, mixer_in;
   logic [7:0]  env_lo_ff, env_lo_in;
   logic [7:0]  env_hi_ff, env_hi_in;
   logic [3:0]  shape_ff, shape_in;
   logic [7:0]  pa_latch_ff, pa_latch_in;
   logic        pa_stale_ff, pa_stale_in;
   logic [7:0]  pb_latch_ff, pb_latch_in;
   logic [5:0]  noise_cnt_ff, noise_cnt_in;
   logic [17:0] lfsr_ff, lfsr_in;
   logic        noise_lvl_ff, noise_lvl_in;
   logic [16:0] env_cnt_ff, env_cnt_in;
   logic [3:0]  env_step_ff, env_step_in;
   logic [3:0]  env_lvl_ff, env_lvl_in;
   logic        env_rise_ff, env_rise_in;
   logic        env_held_ff, env_held_in;

   // tick next state
   logic [11:0] tone_per [VOICES];
   logic [11:0] tk_tone_cnt [VOICES];
   logic        tk_tone_lvl [VOICES];
   logic [3:0]  tk_level [VOICES];
   logic [5:0]  noise_per;
   logic [5:0]  noise_inc;
   logic [17:0] lfsr_fb;
   logic [5:0]  tk_noise_cnt;
   logic [17:0] tk_lfsr;
   logic        tk_noise_lvl;
   logic [15:0] env_per;
   logic        env_wrap;
   logic [16:0] tk_env_cnt;
   logic [3:0]  tk_env_step;
   logic [3:0]  tk_env_lvl;
   logic        tk_env_rise;
   logic        tk_env_held;
   logic [7:0]  key_byte;
   logic [7:0]  rd_value;

   always_comb begin
      for (int ch = 0; ch < VOICES; ch++) begin
         tone_per[ch] = ({tone_hi_ff[ch], tone_lo_ff[ch]} == 12'd0) ? 12'd1
                                                                : {tone_hi_ff[ch], tone_lo_ff[ch]};
         tk_tone_cnt[ch] = tone_cnt_ff[ch] + 12'd1;
         tk_tone_lvl[ch] = tone_lvl_ff[ch];
         if (tk_tone_cnt[ch] >= tone_per[ch]) begin
            tk_tone_cnt[ch] = 12'd0;
            tk_tone_lvl[ch] = ~tone_lvl_ff[ch];
         end
      end
   end

   always_comb begin
      noise_per    = (noise_ff == 5'd0) ? 6'd1 : {1'b0, noise_ff};
      noise_inc    = noise_cnt_ff + 6'd1;
      lfsr_fb      = lfsr_ff[0] ? (lfsr_ff ^ LFSR_TAPS) : lfsr_ff;
      tk_noise_cnt = noise_inc;
      tk_lfsr      = lfsr_ff;
      tk_noise_lvl = noise_lvl_ff;
      if ((noise_inc >= noise_per) && noise_inc[0]) begin
         tk_noise_cnt = 6'd0;
         tk_noise_lvl = noise_lvl_ff ^ lfsr_ff[0] ^ lfsr_ff[1];
         tk_lfsr      = lfsr_fb >> 1;
      end
   end

   always_comb begin
      env_per     = ({env_hi_ff, env_lo_ff} == 16'd0) ? 16'd1 : {env_hi_ff, env_lo_ff};
      env_wrap    = env_cnt_ff >= {env_per, 1'b0};
      tk_env_cnt  = env_wrap ? 17'd1 : env_cnt_ff + 17'd1;
      tk_env_step = env_step_ff;
      tk_env_lvl  = env_lvl_ff;
      tk_env_rise = env_rise_ff;
      tk_env_held = env_held_ff;
      if (env_wrap && !env_held_ff) begin
         tk_env_step = env_step_ff + 4'd1;
         // step counter rolls over after sixteen steps
         if (env_step_ff == 4'd15) begin
            if (!shape_ff[SHAPE_CONT]) begin
               tk_env_lvl  = 4'd0;
               tk_env_held = 1'b1;
            end else begin
               if (shape_ff[SHAPE_ALT]) begin
                  tk_env_rise = ~env_rise_ff;
               end else begin
                  tk_env_lvl = env_rise_ff ? 4'd0 : 4'd15;
               end
               if (shape_ff[SHAPE_HOLD]) begin
                  tk_env_held = 1'b1;
                  tk_env_lvl  = tk_env_rise ? 4'd15 : 4'd0;
               end
            end
         end else if (env_rise_ff) begin
            tk_env_lvl = env_lvl_ff + 4'd1;
         end else begin
            tk_env_lvl = env_lvl_ff - 4'd1;
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < VOICES; ch++) begin
         if ((mixer_ff[ch] | tk_tone_lvl[ch]) &
             (mixer_ff[MIX_NOISE_OFS + ch] | tk_noise_lvl)) begin
            tk_level[ch] = vol_ff[ch][4] ? tk_env_lvl : vol_ff[ch][3:0];
         end else begin
            tk_level[ch] = 4'd0;
         end
      end
   end

   // bus read path
   always_comb begin
      key_byte = (item.row < KEY_ROWS) ? item.key : 8'd0;
      rd_value = BUS_FLOAT;
      if (sel_ff[7:4] == 4'd0) begin
         unique case (sel_ff[3:0])
            REG_TONE_A_LO: rd_value = tone_lo_ff[0];
            REG_TONE_A_HI: rd_value = {4'd0, tone_hi_ff[0]};
            REG_TONE_B_LO: rd_value = tone_lo_ff[1];
            REG_TONE_B_HI: rd_value = {4'd0, tone_hi_ff[1]};
            REG_TONE_C_LO: rd_value = tone_lo_ff[2];
            REG_TONE_C_HI: rd_value = {4'd0, tone_hi_ff[2]};
            REG_NOISE:     rd_value = {3'd0, noise_ff};
            REG_MIXER:     rd_value = reg7_ff;
            REG_VOL_A:     rd_value = {3'd0, vol_ff[0]};
            REG_VOL_B:     rd_value = {3'd0, vol_ff[1]};
            REG_VOL_C:     rd_value = {3'd0, vol_ff[2]};
            REG_ENV_LO:    rd_value = env_lo_ff;
            REG_ENV_HI:    rd_value = env_hi_ff;
            REG_SHAPE:     rd_value = {4'd0, shape_ff};
            REG_PORT_A: begin
               if (!mixer_ff[MIX_PORT_A_IN] || pa_stale_ff) begin
                  rd_value = key_byte;
               end else begin
                  rd_value = pa_latch_ff;
               end
            end
            REG_PORT_B:    rd_value = mixer_ff[MIX_PORT_B_IN] ? pb_latch_ff : BUS_FLOAT;
            default:       rd_value = BUS_FLOAT;
         endcase
      end
   end

   always_comb begin
      sel_in       = sel_ff;
      tone_lo_in   = tone_lo_ff;
      tone_hi_in   = tone_hi_ff;
      vol_in       = vol_ff;
      tone_cnt_in  = tone_cnt_ff;
      tone_lvl_in  = tone_lvl_ff;
      noise_in     = noise_ff;
      reg7_in      = reg7_ff;
      mixer_in     = mixer_ff;
      env_lo_in    = env_lo_ff;
      env_hi_in    = env_hi_ff;
      shape_in     = shape_ff;
      pa_latch_in  = pa_latch_ff;
      pa_stale_in  = pa_stale_ff;
      pb_latch_in  = pb_latch_ff;
      noise_cnt_in = noise_cnt_ff;
      lfsr_in      = lfsr_ff;
      noise_lvl_in = noise_lvl_ff;
      env_cnt_in   = env_cnt_ff;
      env_step_in  = env_step_ff;
      env_lvl_in   = env_lvl_ff;
      env_rise_in  = env_rise_ff;
      env_held_in  = env_held_ff;
      result       = '{read_data: BUS_FLOAT, level_left: 4'd0,
                       level_center: 4'd0, level_right: 4'd0};

      if (item.kind == KIND_TICK) begin
         result.level_left   = tk_level[0];
         result.level_center = tk_level[1];
         result.level_right  = tk_level[2];
         if (fire) begin
            tone_cnt_in  = tk_tone_cnt;
            tone_lvl_in  = tk_tone_lvl;
            noise_cnt_in = tk_noise_cnt;
            lfsr_in      = tk_lfsr;
            noise_lvl_in = tk_noise_lvl;
            env_cnt_in   = tk_env_cnt;
            env_step_in  = tk_env_step;
            env_lvl_in   = tk_env_lvl;
            env_rise_in  = tk_env_rise;
            env_held_in  = tk_env_held;
         end
      end else begin
         unique case (item.ctl)
            BUS_LATCH: begin
               result.read_data = item.data;
               if (fire) begin
                  sel_in = item.data;
               end
            end
            BUS_WRITE: begin
               result.read_data = item.data;
               if (fire && (sel_ff[7:4] == 4'd0)) begin
                  unique case (sel_ff[3:0])
                     REG_TONE_A_LO: tone_lo_in[0] = item.data;
                     REG_TONE_A_HI: tone_hi_in[0] = item.data[3:0];
                     REG_TONE_B_LO: tone_lo_in[1] = item.data;
                     REG_TONE_B_HI: tone_hi_in[1] = item.data[3:0];
                     REG_TONE_C_LO: tone_lo_in[2] = item.data;
                     REG_TONE_C_HI: tone_hi_in[2] = item.data[3:0];
                     REG_NOISE:     noise_in      = item.data[4:0];
                     REG_MIXER: begin
                        reg7_in  = item.data;
                        mixer_in = item.data;
                     end
                     REG_VOL_A:     vol_in[0] = item.data[4:0];
                     REG_VOL_B:     vol_in[1] = item.data[4:0];
                     REG_VOL_C:     vol_in[2] = item.data[4:0];
                     REG_ENV_LO:    env_lo_in = item.data;
                     REG_ENV_HI:    env_hi_in = item.data;
                     REG_SHAPE: begin
                        // shape write restarts the envelope
                        shape_in    = item.data[3:0];
                        env_cnt_in  = 17'd0;
                        env_step_in = 4'd0;
                        env_held_in = 1'b0;
                        env_rise_in = item.data[SHAPE_ATTACK];
                        env_lvl_in  = item.data[SHAPE_ATTACK] ? 4'd0 : 4'd15;
                     end
                     REG_PORT_A: begin
                        pa_latch_in = item.data;
                        pa_stale_in = 1'b0;
                     end
                     REG_PORT_B:    pb_latch_in = item.data;
                     default:       pb_latch_in = pb_latch_ff;
                  endcase
               end
            end
            BUS_READ: begin
               result.read_data = rd_value;
               if (fire && (sel_ff == {4'd0, REG_PORT_A}) && !mixer_ff[MIX_PORT_A_IN]) begin
                  pa_stale_in = 1'b1;
               end
            end
            BUS_IDLE: result.read_data = BUS_FLOAT;
            default:  result.read_data = BUS_FLOAT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 8'd0;
         for (int ch = 0; ch < VOICES; ch++) begin
            tone_lo_ff[ch]  <= 8'd0;
            tone_hi_ff[ch]  <= 4'd0;
            vol_ff[ch]      <= 5'd0;
            tone_cnt_ff[ch] <= 12'd0;
            tone_lvl_ff[ch] <= 1'b1;
         end
         noise_ff     <= 5'd0;
         reg7_ff      <= 8'd0;
         mixer_ff     <= 8'hFF;
         env_lo_ff    <= 8'd0;
         env_hi_ff    <= 8'd0;
         shape_ff     <= 4'd0;
         pa_latch_ff  <= 8'd0;
         pa_stale_ff  <= 1'b1;
         pb_latch_ff  <= 8'hFF;
         noise_cnt_ff <= 6'd0;
         lfsr_ff      <= 18'd1;
         noise_lvl_ff <= 1'b1;
         env_cnt_ff   <= 17'd0;
         env_step_ff  <= 4'd0;
         env_lvl_ff   <= 4'd0;
         env_rise_ff  <= 1'b0;
         env_held_ff  <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         tone_lo_ff   <= tone_lo_in;
         tone_hi_ff   <= tone_hi_in;
         vol_ff       <= vol_in;
         tone_cnt_ff  <= tone_cnt_in;
         tone_lvl_ff  <= tone_lvl_in;
         noise_ff     <= noise_in;
         reg7_ff      <= reg7_in;
         mixer_ff     <= mixer_in;
         env_lo_ff    <= env_lo_in;
         env_hi_ff    <= env_hi_in;
         shape_ff     <= shape_in;
         pa_latch_ff  <= pa_latch_in;
         pa_stale_ff  <= pa_stale_in;
         pb_latch_ff  <= pb_latch_in;
         noise_cnt_ff <= noise_cnt_in;
         lfsr_ff      <= lfsr_in;
         noise_lvl_ff <= noise_lvl_in;
         env_cnt_ff   <= env_cnt_in;
         env_step_ff  <= env_step_in;
         env_lvl_ff   <= env_lvl_in;
         env_rise_ff  <= env_rise_in;
         env_held_ff  <= env_held_in;
      end
   end

endmodule

FILE: design/three_voice_sound_generator_unit.sv
// ----------------------------------------------------------------------------
// three_voice_sound_generator_unit
// three voice sound generator with bus register file and keyboard port
// ----------------------------------------------------------------------------
// each request beat is a bus access (tuser 0) or one sound tick (tuser 1).
// a bus access latches the register address, writes the addressed register
// or reads it back; a tick advances the tone, noise and envelope counters.
// every request beat gives exactly one response beat: the bus byte and the
// three channel levels.
// path: an accepted request beat is held in the input register, is processed
// when the result register can take it and shows on rsp_tvalid from there.
// throughput: one beat per cycle while the receiver keeps rsp_tready high;
// the whole update is one pass of logic between the input register and the
// result register.
// when the receiver holds rsp_tready low the result register keeps its beat,
// the input register keeps the next one, and req_tready drops only when
// both are full.
// reset clears both stages and puts the generator in its power-up state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_voice_sound_generator_unit import tvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // bus_control[1:0], bus_data[9:2], keyboard_row[13:10], key_value[21:14], pad
   input  logic [23:0] req_tdata,
   // kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], level_left[11:8], level_center[15:12], level_right[19:16], pad
   output logic [23:0] rsp_tdata
);

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         out_adv;
   logic         fire;
   logic         req_beat;

   assign out_adv    = !out_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_adv;
   assign req_tready = !s1_valid_ff || out_adv;
   assign req_beat   = req_tvalid && req_tready;

   assign s1_valid_in  = req_beat || (s1_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   tvsg_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s1_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_item_ff.kind <= req_tuser;
         s1_item_ff.ctl  <= bus_ctl_type'(req_tdata[1:0]);
         s1_item_ff.data <= req_tdata[9:2];
         s1_item_ff.row  <= req_tdata[13:10];
         s1_item_ff.key  <= req_tdata[21:14];
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_item_ff.level_right, out_item_ff.level_center,
                        out_item_ff.level_left, out_item_ff.read_data};

   `ASSERT_CLK(a_pending_kept, s1_valid_ff && !out_adv |=> s1_valid_ff, "pending beat dropped")
   `ASSERT_CLK(a_no_overrun, req_beat && s1_valid_ff |-> fire, "input stage overrun")
   `ASSERT_CLK(a_result_shown, fire |=> rsp_tvalid, "processed beat not presented")
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && !s1_valid_ff, "stages not empty")

endmodule
